@@ sv/kdr_pkg.sv @@
`timescale 1ns / 1ps
package kdr_pkg;

  localparam int unsigned MAX_CAPACITY = 1023;
  localparam int unsigned DEPTH        = MAX_CAPACITY + 1;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);
  localparam int unsigned CAP_W        = 10;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned BEST_W       = 32;
  // wide enough to compare weights and capacities of any legal size
  localparam int unsigned WIDE_W       = 17;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_RDCAP,
    S_REPORT
  } kdr_state_e;

endpackage

@@ sv/kdr_ram.sv @@
`timescale 1ns / 1ps
module kdr_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ sv/knapsack_dp_rolling_row.sv @@
`timescale 1ns / 1ps
// result: each item walks n row entries, where n is capacity - max(weight, 1) + 1, from the
//   capacity entry downward, then drains the last write, reads the capacity entry and reports it;
//   nothing is walked when the weight is above the capacity or the capacity is zero
// throughput: no new item is taken until the last one is reported; the row walk runs one entry
//   per cycle through the two-read, one-write row memory, and the report waits on any output stall
// reset: capacity returns to 1023 and a clearing pass zeroes all 1024 row entries;
//   the same pass follows every last item, and no item is taken during it
module knapsack_dp_rolling_row (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kdr_pkg::CAP_W-1:0]     cfg_capacity_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kdr_pkg::WEIGHT_W-1:0]  item_weight_i,
  input  logic [kdr_pkg::VALUE_W-1:0]   item_value_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kdr_pkg::BEST_W-1:0]    best_value_o,
  output logic                          is_final_o
);
  import kdr_pkg::*;

  kdr_state_e state_q, state_d;

  logic [CAP_W-1:0]    capacity_q;
  logic [ADDR_W-1:0]   c_q, c_d;
  logic [ADDR_W-1:0]   w_q, w_d;
  logic [VALUE_W-1:0]  v_q, v_d;
  logic                last_q, last_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic                s1_valid_q, s1_valid_d;
  logic [ADDR_W-1:0]   s1_addr_q, s1_addr_d;
  logic                out_valid_q, out_valid_d;
  logic [BEST_W-1:0]   out_best_q, out_best_d;
  logic                out_final_q, out_final_d;

  logic [WIDE_W-1:0]   cap_wide;
  logic [WIDE_W-1:0]   cap_eff_wide;
  logic [ADDR_W-1:0]   cap_eff;
  logic                in_accept;
  logic                out_free;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BEST_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr_a;
  logic [ADDR_W-1:0]   ram_raddr_b;
  logic [BEST_W-1:0]   ram_rdata_a;
  logic [BEST_W-1:0]   ram_rdata_b;

  logic [BEST_W:0]     take_sum;
  logic [BEST_W-1:0]   take;

  assign cfg_ready_o  = 1'b1;
  assign cap_wide     = WIDE_W'(capacity_q);
  assign cap_eff_wide = (cap_wide > WIDE_W'(MAX_CAPACITY)) ? WIDE_W'(MAX_CAPACITY) : cap_wide;
  assign cap_eff      = cap_eff_wide[ADDR_W-1:0];

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign best_value_o = out_best_q;
  assign is_final_o   = out_final_q;

  // take path: old best at c - weight plus value, saturating
  assign take_sum = {1'b0, ram_rdata_b} + (BEST_W + 1)'(v_q);
  assign take     = take_sum[BEST_W] ? {BEST_W{1'b1}} : take_sum[BEST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_W'(MAX_CAPACITY);
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_capacity_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q         <= c_d;
    w_q         <= w_d;
    v_q         <= v_d;
    last_q      <= last_d;
    s1_addr_q   <= s1_addr_d;
    out_best_q  <= out_best_d;
    out_final_q <= out_final_d;
  end

  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    w_d         = w_q;
    v_d         = v_q;
    last_d      = last_q;
    clr_d       = clr_q;
    s1_valid_d  = 1'b0;
    s1_addr_d   = c_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_best_d  = out_best_q;
    out_final_d = out_final_q;
    ram_re      = 1'b0;
    ram_raddr_a = c_q;
    ram_raddr_b = c_q - w_q;
    // walk write-back has the port unless the row is being cleared
    ram_we      = s1_valid_q && (take > ram_rdata_a);
    ram_waddr   = s1_addr_q;
    ram_wdata   = take;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          w_d    = WIDE_W'(item_weight_i) <= cap_eff_wide
                   ? ADDR_W'(item_weight_i) : '0;
          v_d    = item_value_i;
          last_d = last_item_i;
          c_d    = cap_eff;
          if ((cap_eff != '0) && (WIDE_W'(item_weight_i) <= cap_eff_wide)) begin
            state_d = S_WALK;
          end else begin
            state_d = S_RDCAP;
          end
        end
      end
      S_WALK: begin
        ram_re     = 1'b1;
        s1_valid_d = 1'b1;
        s1_addr_d  = c_q;
        // the walk ends at capacity max(weight, 1)
        if ((c_q == w_q) || (c_q == ADDR_W'(1))) begin
          state_d = S_DRAIN;
        end else begin
          c_d = c_q - ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        // last write lands at the end of this cycle
        state_d = S_RDCAP;
      end
      S_RDCAP: begin
        ram_re      = 1'b1;
        ram_raddr_a = cap_eff;
        state_d     = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_best_d  = ram_rdata_a;
          out_final_d = last_q;
          state_d     = last_q ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  kdr_ram #(
    .DATA_W (BEST_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_row (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // entry zero is never a walk target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_addr_q != '0))
    else $error("walk write-back to entry zero");

  // clearing pass never overlaps a pending walk write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s1_valid_q)
    else $error("walk write-back during clearing pass");

  // the take read always sits at or below the entry being updated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (ram_raddr_b <= ram_raddr_a))
    else $error("take read above update entry");

  // result read only once every walk write has landed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDCAP) |-> !s1_valid_q)
    else $error("result read while a write-back is pending");

  // a result is loaded only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPORT) && (state_d != S_REPORT) |=> out_valid_q)
    else $error("result lost on leaving report");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// mirrors the rolling best-value row and holds the results still owed
class best_row_tracker;
  typedef struct packed {
    logic [kdr_pkg::BEST_W-1:0] best;
    logic                       final_flag;
  } best_due_t;

  logic [kdr_pkg::BEST_W-1:0] row [kdr_pkg::DEPTH];
  logic [kdr_pkg::CAP_W-1:0]  capacity;
  best_due_t                  best_due_q[$];
  int unsigned                error_count;

  function new();
    foreach (row[i]) row[i] = '0;
    capacity    = kdr_pkg::CAP_W'(kdr_pkg::MAX_CAPACITY);
    error_count = 0;
  endfunction

  function void set_capacity(logic [kdr_pkg::CAP_W-1:0] cap);
    capacity = cap;
  endfunction

  function int unsigned owed();
    return best_due_q.size();
  endfunction

  // downward walk so every read sees the row as it was before this candidate
  function void take_candidate(logic [kdr_pkg::WEIGHT_W-1:0] weight,
                               logic [kdr_pkg::VALUE_W-1:0] value, logic last);
    int unsigned             top;
    int unsigned             c;
    logic [kdr_pkg::BEST_W:0] take;
    best_due_t               due;
    top = (capacity > kdr_pkg::MAX_CAPACITY) ? kdr_pkg::MAX_CAPACITY : capacity;
    for (c = top; c >= 1; c--) begin
      if (weight <= c) begin
        take = {1'b0, row[c - weight]} + value;
        if (take[kdr_pkg::BEST_W]) take = {1'b0, {kdr_pkg::BEST_W{1'b1}}};
        if (take[kdr_pkg::BEST_W-1:0] > row[c]) row[c] = take[kdr_pkg::BEST_W-1:0];
      end
    end
    due.best       = row[top];
    due.final_flag = last;
    best_due_q.push_back(due);
    if (last) begin
      foreach (row[i]) row[i] = '0;
    end
  endfunction

  function void check_best(logic [kdr_pkg::BEST_W-1:0] best, logic final_flag);
    best_due_t due;
    if (best_due_q.size() == 0) begin
      $error("unexpected result: best_value %0d is_final %0d", best, final_flag);
      error_count++;
      return;
    end
    due = best_due_q.pop_front();
    if (best !== due.best) begin
      $error("best_value: expected %0d, actual %0d", due.best, best);
      error_count++;
    end
    if (final_flag !== due.final_flag) begin
      $error("is_final: expected %0d, actual %0d", due.final_flag, final_flag);
      error_count++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned QUIET_LIMIT = 10000;
  localparam int unsigned RANDOM_ITEMS = 540;
  localparam int unsigned TAIL_ITEMS = 20;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [kdr_pkg::CAP_W-1:0]     cfg_capacity_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [kdr_pkg::WEIGHT_W-1:0]  item_weight_i;
  logic [kdr_pkg::VALUE_W-1:0]   item_value_i;
  logic                          last_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [kdr_pkg::BEST_W-1:0]    best_value_o;
  logic                          is_final_o;

  best_row_tracker tracker;
  bit              gaps_on;
  bit              stalls_on;
  int unsigned     quiet_cycles = 0;

  knapsack_dp_rolling_row DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .item_weight_i  (item_weight_i),
    .item_value_i   (item_value_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_value_o   (best_value_o),
    .is_final_o     (is_final_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver back-pressure in bursts
  always begin
    @(posedge clk_i);
    if (stalls_on && $urandom_range(0, 11) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_best(best_value_o, is_final_o);
  end

  // counts cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("knapsack_dp_rolling_row: mismatch");
      $finish;
    end
  end

  task automatic send_candidate(input logic [kdr_pkg::WEIGHT_W-1:0] weight,
                                input logic [kdr_pkg::VALUE_W-1:0] value, input logic last);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    item_weight_i <= weight;
    item_value_i  <= value;
    last_item_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_candidate(weight, value, last);
  endtask

  // block must be idle before the capacity changes
  task automatic write_capacity(input logic [kdr_pkg::CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_capacity(cap);
  endtask

  task automatic random_phase(inout int unsigned sent);
    logic [kdr_pkg::CAP_W-1:0]    cap;
    logic [kdr_pkg::WEIGHT_W-1:0] weight;
    logic [kdr_pkg::VALUE_W-1:0]  value;
    logic                         last;
    int unsigned                  count;
    int unsigned                  pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) cap = kdr_pkg::CAP_W'(kdr_pkg::MAX_CAPACITY);
    else if (pick == 1) cap = '0;
    else if (pick <= 4) cap = kdr_pkg::CAP_W'($urandom_range(65, 400));
    else cap = kdr_pkg::CAP_W'($urandom_range(1, 64));
    // big capacities walk long rows, so keep those phases short
    count = (cap >= 65) ? $urandom_range(3, 8) : $urandom_range(8, 30);
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    write_capacity(cap);
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) weight = kdr_pkg::WEIGHT_W'($urandom);
      else if (pick == 1) weight = '0;
      else if (pick == 2) weight = kdr_pkg::WEIGHT_W'(cap);
      else if (pick == 3) weight = kdr_pkg::WEIGHT_W'(cap + 1 + $urandom_range(0, 20));
      else weight = (cap == 0) ? '0 : kdr_pkg::WEIGHT_W'($urandom_range(1, cap));
      pick = $urandom_range(0, 9);
      if (pick == 0) value = '1;
      else if (pick == 1) value = '0;
      else value = kdr_pkg::VALUE_W'($urandom);
      // sets sometimes run on into the next capacity
      if (k == count - 1) last = ($urandom_range(0, 1) == 1);
      else last = ($urandom_range(0, 9) == 0);
      send_candidate(weight, value, last);
      sent++;
    end
  endtask

  initial begin
    int unsigned sent;
    tracker        = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_capacity_i = '0;
    in_valid_i     = 1'b0;
    item_weight_i  = '0;
    item_value_i   = '0;
    last_item_i    = 1'b0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    sent           = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity, weight equal to capacity, zero weight, overweight
    send_candidate(16'd1023, 16'd40000, 1'b0);
    send_candidate(16'd0, 16'hFFFF, 1'b0);
    send_candidate(16'hFFFF, 16'hFFFF, 1'b0);
    send_candidate(16'd1024, 16'd1, 1'b0);
    send_candidate(16'd1, 16'd0, 1'b0);
    send_candidate(16'd512, 16'hFFFF, 1'b1);
    // capacity zero reports entry zero
    write_capacity('0);
    send_candidate(16'd0, 16'hFFFF, 1'b0);
    send_candidate(16'hFFFF, 16'd0, 1'b1);
    write_capacity(10'd1);
    send_candidate(16'd1, 16'd7, 1'b0);
    send_candidate(16'd0, 16'd3, 1'b0);
    send_candidate(16'd2, 16'd9, 1'b0);
    send_candidate(16'd1, 16'hFFFF, 1'b0);
    // capacity shrinks and grows back inside one set, stale upper entries stay
    write_capacity(10'd6);
    send_candidate(16'd2, 16'd10, 1'b0);
    send_candidate(16'd3, 16'd15, 1'b0);
    write_capacity(10'd4);
    send_candidate(16'd1, 16'd4, 1'b0);
    write_capacity(10'd6);
    send_candidate(16'd2, 16'd1, 1'b0);
    send_candidate(16'd6, 16'd100, 1'b1);
    write_capacity(10'd1023);
    send_candidate(16'd1000, 16'hFFFF, 1'b1);

    while (sent < RANDOM_ITEMS) random_phase(sent);

    // no idling from here on
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_capacity(10'd48);
    for (int unsigned k = 0; k < TAIL_ITEMS; k++) begin
      send_candidate(kdr_pkg::WEIGHT_W'($urandom_range(0, 48)), kdr_pkg::VALUE_W'($urandom),
                     k == TAIL_ITEMS - 1);
    end
    in_valid_i <= 1'b0;

    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (tracker.error_count == 0) begin
      $display("knapsack_dp_rolling_row: match");
    end else begin
      $display("knapsack_dp_rolling_row: mismatch");
    end
    $finish;
  end
endmodule
